>>> rtl/core/mqsl_pkg.sv
`timescale 1ns / 1ps
package mqsl_pkg;

	// operation codes
	localparam logic [2:0] OP_ALLOC   = 3'd0;
	localparam logic [2:0] OP_APPEND  = 3'd1;
	localparam logic [2:0] OP_POP     = 3'd2;
	localparam logic [2:0] OP_UNLINK  = 3'd3;
	localparam logic [2:0] OP_PEEK    = 3'd4;
	localparam logic [2:0] OP_COUNT   = 3'd5;
	localparam logic [2:0] OP_RELEASE = 3'd6;

	// queue kinds, also stored as slot owner
	localparam logic [2:0] KIND_FREE   = 3'd0;
	localparam logic [2:0] KIND_SLICE  = 3'd1;
	localparam logic [2:0] KIND_BUFDEP = 3'd2;
	localparam logic [2:0] KIND_ROWDEP = 3'd3;
	localparam logic [2:0] KIND_DMA    = 3'd4;
	localparam logic [2:0] KIND_NAND   = 3'd5;
	localparam logic [2:0] OWNER_NONE  = 3'd7;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_MISMATCH = 2'd2;

	typedef struct packed {
		logic [2:0] op;
		logic [2:0] queue_kind;
		logic [2:0] channel;
		logic [2:0] way;
		logic [6:0] slot;
	} in_t;

	typedef struct packed {
		logic [7:0] result_slot;
		logic [1:0] status;
		logic [7:0] queue_count;
		logic [7:0] blocked_total;
		logic [7:0] nand_pending;
	} out_t;

endpackage

>>> rtl/core/mqsl_ram.sv
`timescale 1ns / 1ps
module mqsl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write one word, read one word registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/core/multi_queue_slot_list_manager.sv
`timescale 1ns / 1ps
// Channel  Direction  Payload          Transfer
// in       input      mqsl_pkg::in_t   in_valid & in_ready
// out      output     mqsl_pkg::out_t  out_valid & out_ready
//
// Each operation reads its records in S_RD and checks them in S_EVAL. Peek,
// count and failed checks then go to S_DONE; an unlink passes S_RDL, S_UNL
// and S_WB; one followed by a push to the free list adds S_PSH1 and S_PSH2
// before S_WB; the dependent reads of the link and queue memories set this.
// After reset a clearing pass fills the memories while in_ready stays low.
// A stalled result waits in the output register; the next item is accepted.
module multi_queue_slot_list_manager #(
	parameter int POOL_SLOTS = 128,
	parameter int CHANNELS   = 8,
	parameter int WAYS       = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  mqsl_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output mqsl_pkg::out_t out_data
);
	import mqsl_pkg::*;

	localparam int LANES = CHANNELS * WAYS;
	localparam int NQ    = 4 + 2 * LANES;
	localparam int QDEP  = NQ - 1;
	localparam int PW    = $clog2(POOL_SLOTS + 1);
	localparam int SIW   = $clog2(POOL_SLOTS);
	localparam int LW    = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int QW    = $clog2(NQ);
	localparam int QAW   = $clog2(QDEP);
	localparam int CLRN  = (POOL_SLOTS > QDEP) ? POOL_SLOTS : QDEP;
	localparam int CLW   = $clog2(CLRN);
	localparam int MW    = 3 + LW;
	localparam logic [PW-1:0] NONE = PW'(POOL_SLOTS);

	typedef struct packed {
		logic [PW-1:0] head;
		logic [PW-1:0] tail;
		logic [PW-1:0] size;
	} qrec_t;

	typedef struct packed {
		logic [2:0]    owner;
		logic [LW-1:0] lane;
	} meta_t;

	typedef enum logic [9:0] {
		S_CLR  = 10'b0000000001,
		S_IDLE = 10'b0000000010,
		S_RD   = 10'b0000000100,
		S_EVAL = 10'b0000001000,
		S_RDL  = 10'b0000010000,
		S_UNL  = 10'b0000100000,
		S_PSH1 = 10'b0001000000,
		S_PSH2 = 10'b0010000000,
		S_WB   = 10'b0100000000,
		S_DONE = 10'b1000000000
	} state_t;

	function automatic logic [QW-1:0] queue_index(logic [2:0] kind, logic [LW-1:0] lane);
		unique case (kind)
			KIND_SLICE:  return QW'(1);
			KIND_BUFDEP: return QW'(2);
			KIND_DMA:    return QW'(3);
			KIND_ROWDEP: return QW'(4 + int'(lane));
			KIND_NAND:   return QW'(4 + LANES + int'(lane));
			default:     return QW'(0);
		endcase
	endfunction

	// fold channel and way into range modulo CHANNELS and WAYS
	function automatic logic [LW-1:0] lane_of(logic [2:0] ch, logic [2:0] wy);
		int c, w;
		c = 0;
		w = 0;
		for (int i = 0; i < 8; i++) begin
			if (ch == 3'(i)) c = i % CHANNELS;
			if (wy == 3'(i)) w = i % WAYS;
		end
		return LW'(c * WAYS + w);
	endfunction

	state_t         state_q;
	logic [CLW-1:0] clr_q;
	logic [2:0]     op_q;
	logic [2:0]     kind_q;
	logic [LW-1:0]  lane_q;
	logic [6:0]     slot_q;
	logic [QW-1:0]  q_q;
	logic           kind_ok_q;
	logic           slot_ok_q;
	logic [PW-1:0]  t_q;
	logic [PW-1:0]  res_q;
	logic [1:0]     st_q;
	qrec_t          qrec_q;
	logic           unl_free_q;
	logic           psh_free_q;
	logic [2:0]     psh_owner_q;
	logic [LW-1:0]  psh_lane_q;
	logic           repush_q;
	logic [PW-1:0]  fhead_q;
	logic [PW-1:0]  ftail_q;
	logic [PW-1:0]  fsize_q;
	logic [PW-1:0]  blk_q;
	logic [PW-1:0]  nand_q;
	logic           out_valid_q;
	out_t           out_q;

	// memory ports
	logic            nx_we, pv_we, mt_we, qr_we;
	logic [SIW-1:0]  nx_waddr, pv_waddr, mt_waddr;
	logic [PW-1:0]   nx_wdata, pv_wdata;
	logic [MW-1:0]   mt_wdata;
	logic [QAW-1:0]  qr_waddr, qr_raddr;
	qrec_t           qr_wdata;
	logic [SIW-1:0]  lk_raddr, mt_raddr;
	logic [PW-1:0]   nx_rdata, pv_rdata;
	logic [MW-1:0]   mt_rdata;
	logic [3*PW-1:0] qr_rdata;

	// decode and working views
	logic [LW-1:0] lane_in;
	logic          acc;
	meta_t         meta_rd;
	qrec_t         free_rec, cur_e, cur, upd;
	logic          sel_free;
	logic [PW-1:0] p_lk, n_lk;
	logic [PW-1:0] cnt;
	logic          show;
	logic          is_blk, is_nand, do_out;

	// evaluation results
	state_t        ev_next;
	logic [1:0]    ev_st;
	logic [PW-1:0] ev_res;
	logic [PW-1:0] ev_t;
	logic          ev_repush;
	logic          ev_unl_free;
	logic          ev_psh_free;
	logic [2:0]    ev_owner;
	logic [LW-1:0] ev_lane;

	assign lane_in  = lane_of(in_data.channel, in_data.way);
	assign in_ready = (state_q == S_IDLE);
	assign acc      = in_valid & in_ready;
	assign meta_rd  = meta_t'(mt_rdata);
	assign free_rec = '{head: fhead_q, tail: ftail_q, size: fsize_q};
	assign cur_e    = (q_q == '0) ? free_rec : qrec_t'(qr_rdata);
	assign sel_free = (state_q == S_UNL) ? unl_free_q : psh_free_q;
	assign cur      = sel_free ? free_rec : qrec_q;
	assign p_lk     = pv_rdata;
	assign n_lk     = nx_rdata;
	assign is_blk   = (kind_q == KIND_BUFDEP) || (kind_q == KIND_ROWDEP);
	assign is_nand  = (kind_q == KIND_NAND);
	assign show     = kind_ok_q || (op_q == OP_ALLOC) || (op_q == OP_RELEASE);
	assign cnt      = !show ? '0 : ((q_q == '0) ? fsize_q : qrec_q.size);
	assign do_out   = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// check the operation against the fetched records
	always_comb begin
		ev_next     = S_DONE;
		ev_st       = ST_OK;
		ev_res      = NONE;
		ev_t        = PW'(slot_q);
		ev_repush   = 1'b0;
		ev_unl_free = (q_q == '0);
		ev_psh_free = (q_q == '0);
		ev_owner    = kind_q;
		ev_lane     = lane_q;
		unique case (op_q)
			OP_ALLOC: begin
				ev_unl_free = 1'b1;
				if (fhead_q == NONE) begin
					ev_st = ST_EMPTY;
				end else begin
					ev_t    = fhead_q;
					ev_res  = fhead_q;
					ev_next = S_RDL;
				end
			end
			OP_APPEND: begin
				if (!kind_ok_q || !slot_ok_q || meta_rd.owner != OWNER_NONE)
					ev_st = ST_MISMATCH;
				else
					ev_next = S_PSH1;
			end
			OP_POP: begin
				if (!kind_ok_q) begin
					ev_st = ST_MISMATCH;
				end else if (cur_e.head == NONE) begin
					ev_st = ST_EMPTY;
				end else begin
					ev_t      = cur_e.head;
					ev_res    = cur_e.head;
					ev_repush = (kind_q == KIND_NAND);
					ev_next   = S_RDL;
				end
			end
			OP_PEEK: begin
				if (!kind_ok_q)
					ev_st = ST_MISMATCH;
				else if (cur_e.head == NONE)
					ev_st = ST_EMPTY;
				else
					ev_res = cur_e.head;
			end
			OP_UNLINK: begin
				ev_repush = (kind_q == KIND_DMA);
				if (!kind_ok_q || !slot_ok_q || meta_rd.owner != kind_q
					|| ((kind_q == KIND_ROWDEP || kind_q == KIND_NAND)
					&& meta_rd.lane != lane_q))
					ev_st = ST_MISMATCH;
				else
					ev_next = S_RDL;
			end
			OP_COUNT: begin
				if (!kind_ok_q) ev_st = ST_MISMATCH;
			end
			OP_RELEASE: begin
				ev_psh_free = 1'b1;
				ev_owner    = KIND_FREE;
				ev_lane     = '0;
				if (!slot_ok_q || meta_rd.owner != OWNER_NONE)
					ev_st = ST_MISMATCH;
				else
					ev_next = S_PSH1;
			end
			default: begin
			end
		endcase
	end

	// updated record for unlink and push
	always_comb begin
		upd = cur;
		if (state_q == S_UNL) begin
			if (p_lk == NONE) upd.head = n_lk;
			if (n_lk == NONE) upd.tail = p_lk;
			upd.size = cur.size - PW'(1);
		end else begin
			if (cur.tail == NONE) upd.head = t_q;
			upd.tail = t_q;
			upd.size = cur.size + PW'(1);
		end
	end

	// drive memory ports from the sequencer state
	always_comb begin
		nx_we    = 1'b0;
		pv_we    = 1'b0;
		mt_we    = 1'b0;
		qr_we    = 1'b0;
		nx_waddr = SIW'(t_q);
		pv_waddr = SIW'(t_q);
		mt_waddr = SIW'(t_q);
		nx_wdata = NONE;
		pv_wdata = cur.tail;
		mt_wdata = {OWNER_NONE, LW'(0)};
		qr_waddr = (q_q == '0) ? '0 : QAW'(q_q - QW'(1));
		qr_raddr = qr_waddr;
		qr_wdata = qrec_q;
		lk_raddr = SIW'(t_q);
		mt_raddr = SIW'(slot_q);
		unique case (state_q)
			S_CLR: begin
				nx_we    = int'(clr_q) < POOL_SLOTS;
				pv_we    = nx_we;
				mt_we    = nx_we;
				qr_we    = int'(clr_q) < QDEP;
				nx_waddr = SIW'(clr_q);
				pv_waddr = SIW'(clr_q);
				mt_waddr = SIW'(clr_q);
				nx_wdata = PW'(int'(clr_q) + 1);
				pv_wdata = (clr_q == '0) ? NONE : PW'(int'(clr_q) - 1);
				mt_wdata = {KIND_FREE, LW'(0)};
				qr_waddr = QAW'(clr_q);
				qr_wdata = '{head: NONE, tail: NONE, size: '0};
			end
			S_UNL: begin
				nx_we    = (p_lk != NONE);
				nx_waddr = SIW'(p_lk);
				nx_wdata = n_lk;
				pv_we    = (n_lk != NONE);
				pv_waddr = SIW'(n_lk);
				pv_wdata = p_lk;
				mt_we    = 1'b1;
			end
			S_PSH1: begin
				nx_we    = 1'b1;
				pv_we    = 1'b1;
				mt_we    = 1'b1;
				mt_wdata = {psh_owner_q, psh_lane_q};
			end
			S_PSH2: begin
				nx_we    = (cur.tail != NONE);
				nx_waddr = SIW'(cur.tail);
				nx_wdata = t_q;
			end
			S_WB: begin
				qr_we = (q_q != '0);
			end
			default: begin
			end
		endcase
	end

	mqsl_ram #(.WIDTH(PW), .DEPTH(POOL_SLOTS)) u_next_ram (
		.clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
		.raddr(lk_raddr), .rdata(nx_rdata)
	);

	mqsl_ram #(.WIDTH(PW), .DEPTH(POOL_SLOTS)) u_prev_ram (
		.clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
		.raddr(lk_raddr), .rdata(pv_rdata)
	);

	mqsl_ram #(.WIDTH(MW), .DEPTH(POOL_SLOTS)) u_meta_ram (
		.clk(clk), .we(mt_we), .waddr(mt_waddr), .wdata(mt_wdata),
		.raddr(mt_raddr), .rdata(mt_rdata)
	);

	mqsl_ram #(.WIDTH(3 * PW), .DEPTH(QDEP)) u_queue_ram (
		.clk(clk), .we(qr_we), .waddr(qr_waddr), .wdata(qr_wdata),
		.raddr(qr_raddr), .rdata(qr_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			fhead_q     <= '0;
			ftail_q     <= PW'(POOL_SLOTS - 1);
			fsize_q     <= PW'(POOL_SLOTS);
			blk_q       <= '0;
			nand_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + CLW'(1);
					if (clr_q == CLW'(CLRN - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (acc) state_q <= S_RD;
				end
				S_RD: state_q <= S_EVAL;
				S_EVAL: state_q <= ev_next;
				S_RDL: state_q <= S_UNL;
				S_UNL: begin
					if (unl_free_q) begin
						fhead_q <= upd.head;
						ftail_q <= upd.tail;
						fsize_q <= upd.size;
					end
					if (op_q != OP_ALLOC) begin
						if (is_blk) blk_q <= blk_q - PW'(1);
						if (is_nand) nand_q <= nand_q - PW'(1);
					end
					state_q <= repush_q ? S_PSH1 : S_WB;
				end
				S_PSH1: state_q <= S_PSH2;
				S_PSH2: begin
					if (psh_free_q) begin
						fhead_q <= upd.head;
						ftail_q <= upd.tail;
						fsize_q <= upd.size;
					end
					if (op_q == OP_APPEND) begin
						if (is_blk) blk_q <= blk_q + PW'(1);
						if (is_nand) nand_q <= nand_q + PW'(1);
					end
					state_q <= S_WB;
				end
				S_WB: state_q <= S_DONE;
				S_DONE: begin
					if (do_out) state_q <= S_IDLE;
				end
				default: state_q <= S_CLR;
			endcase
		end
	end

	// operation payload registers
	always_ff @(posedge clk) begin
		if (acc) begin
			op_q      <= in_data.op;
			kind_q    <= in_data.queue_kind;
			lane_q    <= lane_in;
			slot_q    <= in_data.slot;
			kind_ok_q <= in_data.queue_kind <= KIND_NAND;
			slot_ok_q <= int'(in_data.slot) < POOL_SLOTS;
			q_q       <= (in_data.op == OP_ALLOC || in_data.op == OP_RELEASE)
				? '0 : queue_index(in_data.queue_kind, lane_in);
		end
		if (state_q == S_EVAL) begin
			qrec_q      <= qrec_t'(qr_rdata);
			st_q        <= ev_st;
			res_q       <= ev_res;
			repush_q    <= ev_repush;
			unl_free_q  <= ev_unl_free;
			psh_free_q  <= ev_psh_free;
			psh_owner_q <= ev_owner;
			psh_lane_q  <= ev_lane;
			t_q         <= ev_t;
		end
		// record update of a non-free queue
		if ((state_q == S_UNL && !unl_free_q) || (state_q == S_PSH2 && !psh_free_q))
			qrec_q <= upd;
		// set up the push of a returned slot to the free list
		if (state_q == S_UNL && repush_q) begin
			psh_free_q  <= 1'b1;
			psh_owner_q <= KIND_FREE;
			psh_lane_q  <= '0;
		end
		if (do_out) begin
			out_q.result_slot   <= 8'(res_q);
			out_q.status        <= st_q;
			out_q.queue_count   <= 8'(cnt);
			out_q.blocked_total <= 8'(blk_q);
			out_q.nand_pending  <= 8'(nand_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(fsize_q) <= POOL_SLOTS)
		else $error("free list size beyond pool");
	a_free_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(fhead_q == NONE) == (fsize_q == '0))
		else $error("free list head and size disagree");
	a_totals: assert property (@(posedge clk) disable iff (!arst_n)
		int'(blk_q) + int'(nand_q) <= POOL_SLOTS)
		else $error("queued totals beyond pool");
`endif

endmodule
